// ===== hdl/cme_pkg.sv =====
// Shared types, codes and a helper function of the sparse matrix element update block.
package cme_pkg;

  localparam int MAX_ROWS_DEF    = 4096;
  localparam int MAX_ENTRIES_DEF = 16384;
  localparam int MAX_COLS_DEF    = 4096;

  localparam int SCALED_W = 48;

  localparam logic signed [31:0] MULT_RESET = 32'sd65536;

  localparam logic CFG_ROW_COUNT  = 1'b0;
  localparam logic CFG_MULTIPLIER = 1'b1;

  typedef enum logic [2:0] {
    FN_LOAD_ROW,
    FN_LOAD_COL,
    FN_SET,
    FN_ADD,
    FN_ERASE,
    FN_READ,
    FN_CLEAR,
    FN_NOP
  } func_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_ROW_RANGE,
    STS_NOT_FOUND
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [12:0]        row;
    logic [11:0]        col;
    logic [14:0]        slot;
    logic signed [31:0] value;
    logic               last_of_batch;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic               batch_end;
  } out_item_t;

  typedef enum logic [1:0] {
    SOP_NONE,
    SOP_LOAD_ROW,
    SOP_LOAD_COL,
    SOP_FIND
  } sop_t;

  typedef struct packed {
    sop_t        op;
    logic [12:0] row;
    logic [11:0] col;
    logic [14:0] slot;
  } srch_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_res_t;

  typedef enum logic [2:0] {
    VOP_NONE,
    VOP_SET,
    VOP_ADD,
    VOP_ERASE,
    VOP_READ,
    VOP_CLEAR
  } vop_t;

  typedef enum logic [2:0] {
    SR_IDLE,
    SR_FIRST,
    SR_LAST,
    SR_CMP,
    SR_CHECK
  } srch_state_t;

  typedef enum logic [1:0] {
    VS_CLEAR,
    VS_IDLE,
    VS_MODIFY
  } val_state_t;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_VALUE,
    ST_DONE
  } top_state_t;

  // Saturates a wide signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [SCALED_W:0] v);
    logic [31:0] r;
    if (v > (SCALED_W + 1)'(64'sd2147483647)) begin
      r = 32'h7FFF_FFFF;
    end else if (v < (SCALED_W + 1)'(-64'sd2147483648)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/cme_scale.sv =====
// Two-stage Q16.16 scaling pipeline: multiply, then round to nearest.
module cme_scale (
  input  logic                                clk,
  input  logic signed [31:0]                  value,
  input  logic signed [31:0]                  multiplier,
  output logic signed [cme_pkg::SCALED_W-1:0] scaled
);

  logic signed [63:0] prod;
  logic signed [63:0] biased;

  assign biased = prod + 64'sd32768;

  always_ff @(posedge clk) begin
    prod   <= 64'(value) * 64'(multiplier);
    // Dropping the low 16 bits of a two's complement value is a floor.
    scaled <= biased[63:16];
  end

endmodule

// ===== hdl/cme_search.sv =====
// Row start and column index memories with the binary search sequencer.
module cme_search #(
  parameter int MAX_ROWS    = cme_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = cme_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cme_pkg::srch_cmd_t  cmd,
  output cme_pkg::srch_res_t  res,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] slot
);

  localparam int RA = $clog2(MAX_ROWS + 1);
  localparam int EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW = $clog2(MAX_ENTRIES + 1);

  logic [14:0] rs_mem [MAX_ROWS + 1];
  logic [11:0] ci_mem [MAX_ENTRIES];

  logic          rs_we;
  logic [RA-1:0] rs_wa, rs_ra;
  logic [14:0]   rs_rd;
  logic          ci_we;
  logic [EA-1:0] ci_wa, ci_ra;
  logic [11:0]   ci_rd;

  cme_pkg::srch_state_t state, state_next;
  logic [RA-1:0] row_q, row_q_next;
  logic [11:0]   col_q, col_q_next;
  logic [14:0]   first, first_next;
  logic [EW-1:0] last, last_next;
  logic [EW-1:0] lo, lo_next;
  logic [EW-1:0] hi, hi_next;
  logic [EW-1:0] mid, mid_next;

  logic [31:0]   row32, slot32, last32;
  logic [EW-1:0] lo_c, hi_c, mid_c, first_e;

  assign row32  = 32'(cmd.row);
  assign slot32 = 32'(cmd.slot);
  assign slot   = lo[EA-1:0];

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= cmd.slot;
    end
    rs_rd <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (ci_we) begin
      ci_mem[ci_wa] <= cmd.col;
    end
    ci_rd <= ci_mem[ci_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cme_pkg::SR_IDLE;
    end else begin
      state <= state_next;
    end
    row_q <= row_q_next;
    col_q <= col_q_next;
    first <= first_next;
    last  <= last_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
  end

  always_comb begin
    state_next = state;
    row_q_next = row_q;
    col_q_next = col_q;
    first_next = first;
    last_next  = last;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rs_we      = 1'b0;
    rs_wa      = row32[RA-1:0];
    rs_ra      = row_q;
    ci_we      = 1'b0;
    ci_wa      = slot32[EA-1:0];
    ci_ra      = mid[EA-1:0];
    res        = '0;
    last32     = 32'(rs_rd);
    first_e    = EW'(first);
    lo_c       = lo;
    hi_c       = hi;
    mid_c      = mid;
    unique case (state)
      cme_pkg::SR_IDLE: begin
        unique case (cmd.op)
          cme_pkg::SOP_LOAD_ROW: rs_we = 1'b1;
          cme_pkg::SOP_LOAD_COL: ci_we = 1'b1;
          cme_pkg::SOP_FIND: begin
            rs_ra      = row32[RA-1:0];
            row_q_next = row32[RA-1:0];
            col_q_next = cmd.col;
            state_next = cme_pkg::SR_FIRST;
          end
          default: ;
        endcase
      end
      cme_pkg::SR_FIRST: begin
        first_next = rs_rd;
        rs_ra      = row_q + RA'(1);
        state_next = cme_pkg::SR_LAST;
      end
      cme_pkg::SR_LAST: begin
        // The end of the row is clamped to the size of the entry store.
        if (last32 > 32'(MAX_ENTRIES)) begin
          last32 = 32'(MAX_ENTRIES);
        end
        if (32'(first) >= last32) begin
          res.done   = 1'b1;
          state_next = cme_pkg::SR_IDLE;
        end else begin
          mid_c      = first_e + ((EW'(last32) - first_e) >> 1);
          last_next  = EW'(last32);
          lo_next    = first_e;
          hi_next    = EW'(last32);
          mid_next   = mid_c;
          ci_ra      = mid_c[EA-1:0];
          state_next = cme_pkg::SR_CMP;
        end
      end
      cme_pkg::SR_CMP: begin
        if (ci_rd < col_q) begin
          lo_c = mid + EW'(1);
        end else begin
          hi_c = mid;
        end
        lo_next = lo_c;
        hi_next = hi_c;
        if (lo_c < hi_c) begin
          mid_c    = lo_c + ((hi_c - lo_c) >> 1);
          mid_next = mid_c;
          ci_ra    = mid_c[EA-1:0];
        end else if (lo_c < last) begin
          ci_ra      = lo_c[EA-1:0];
          state_next = cme_pkg::SR_CHECK;
        end else begin
          res.done   = 1'b1;
          state_next = cme_pkg::SR_IDLE;
        end
      end
      cme_pkg::SR_CHECK: begin
        res.done   = 1'b1;
        res.found  = (ci_rd == col_q);
        state_next = cme_pkg::SR_IDLE;
      end
      default: state_next = cme_pkg::SR_IDLE;
    endcase
  end

endmodule

// ===== hdl/cme_value.sv =====
// Value memory with read-modify-write for element updates and a clearing sweep.
module cme_value #(
  parameter int MAX_ENTRIES = cme_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cme_pkg::vop_t                       op,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] slot,
  input  logic signed [cme_pkg::SCALED_W-1:0] scaled,
  output logic                                done,
  output logic signed [31:0]                  rdata
);

  localparam int EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [31:0] v_mem [MAX_ENTRIES];

  logic          we;
  logic [EA-1:0] wa, ra;
  logic [31:0]   wd;
  logic [31:0]   rd;

  cme_pkg::val_state_t state, state_next;
  cme_pkg::vop_t       op_q, op_q_next;
  logic [EA-1:0]       slot_q, slot_q_next;
  logic [EA-1:0]       cnt, cnt_next;

  logic signed [cme_pkg::SCALED_W:0] sum;

  assign rdata = rd;
  assign sum   = (cme_pkg::SCALED_W + 1)'($signed(rd)) + (cme_pkg::SCALED_W + 1)'(scaled);

  always_ff @(posedge clk) begin
    if (we) begin
      v_mem[wa] <= wd;
    end
    rd <= v_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cme_pkg::VS_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    op_q   <= op_q_next;
    slot_q <= slot_q_next;
  end

  always_comb begin
    state_next  = state;
    op_q_next   = op_q;
    slot_q_next = slot_q;
    cnt_next    = cnt;
    we          = 1'b0;
    wa          = slot;
    wd          = '0;
    ra          = slot;
    done        = 1'b0;
    unique case (state)
      cme_pkg::VS_CLEAR: begin
        we = 1'b1;
        wa = cnt;
        if (cnt == EA'(MAX_ENTRIES - 1)) begin
          cnt_next   = '0;
          done       = 1'b1;
          state_next = cme_pkg::VS_IDLE;
        end else begin
          cnt_next = cnt + EA'(1);
        end
      end
      cme_pkg::VS_IDLE: begin
        unique case (op)
          cme_pkg::VOP_SET, cme_pkg::VOP_ADD, cme_pkg::VOP_ERASE, cme_pkg::VOP_READ: begin
            op_q_next   = op;
            slot_q_next = slot;
            state_next  = cme_pkg::VS_MODIFY;
          end
          cme_pkg::VOP_CLEAR: state_next = cme_pkg::VS_CLEAR;
          default: ;
        endcase
      end
      cme_pkg::VS_MODIFY: begin
        // The old value arrives in the cycle after the read was issued.
        wa = slot_q;
        unique case (op_q)
          cme_pkg::VOP_SET: begin
            we = 1'b1;
            wd = cme_pkg::sat32((cme_pkg::SCALED_W + 1)'(scaled));
          end
          cme_pkg::VOP_ADD: begin
            we = 1'b1;
            wd = cme_pkg::sat32(sum);
          end
          cme_pkg::VOP_ERASE: we = 1'b1;
          default: ;
        endcase
        done       = 1'b1;
        state_next = cme_pkg::VS_IDLE;
      end
      default: state_next = cme_pkg::VS_IDLE;
    endcase
  end

endmodule

// ===== hdl/csr_matrix_element_update.sv =====
// Top level of the compressed-sparse-row matrix element update block.
//
// Usage. Input beats arrive on in_valid/in_stall with an in_item_t payload,
// and every beat yields exactly one out_item_t beat on out_valid/out_stall.
// Registers row_count and multiplier are written over the cfg channel, which
// is always ready; write them only while no item is in flight.
// Operation. One item is worked on at a time. Loads, range errors and the
// no-operation code go from the dispatch state straight to the done state,
// which loads the result register. An element access takes a dispatch step,
// 2 row start reads, a series of binary search probes, at most one check
// read and, for a found element, a value memory read-modify-write. The
// probes are serialized by the search sequencer and the single read port of
// the column index memory. After each item the controller returns to the
// idle state, where the next beat is taken. Clearing all values sweeps the
// value memory one entry per cycle.
// Reset. After rst the value memory is zeroed by the same sweep, during which
// in_stall is high.
// Stalls. The result sits in an output register; while the receiver stalls,
// the next input beat is still accepted and processed, and its result waits
// until the output register frees up.
module csr_matrix_element_update #(
  parameter int MAX_ROWS    = cme_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = cme_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_COLS    = cme_pkg::MAX_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cme_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cme_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cme_pkg::top_state_t state, state_next;
  cme_pkg::in_item_t   item;
  cme_pkg::status_t    status_q, status_q_next;
  logic signed [31:0]  rd_q, rd_q_next;
  logic                out_load;

  logic [12:0]        row_count;
  logic signed [31:0] multiplier;

  cme_pkg::srch_cmd_t scmd;
  cme_pkg::srch_res_t sres;
  logic [EA-1:0]      sslot;
  cme_pkg::vop_t      vop;
  logic               vdone;
  logic signed [31:0] vrdata;
  logic signed [cme_pkg::SCALED_W-1:0] scaled;

  logic row_bad;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != cme_pkg::ST_IDLE);
  assign row_bad   = (32'(item.row) >= 32'(row_count)) || (32'(item.row) >= 32'(MAX_ROWS));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      multiplier <= cme_pkg::MULT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cme_pkg::CFG_ROW_COUNT:  row_count  <= cfg_data[12:0];
        cme_pkg::CFG_MULTIPLIER: multiplier <= $signed(cfg_data);
      endcase
    end
  end

  // The item register holds the accepted beat for the whole operation, so
  // the scaling pipeline settles long before the value memory needs it.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    status_q <= status_q_next;
    rd_q     <= rd_q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cme_pkg::ST_BOOT;
    end else begin
      state <= state_next;
    end
  end

  // The output register frees up when its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.status     <= status_q;
      out_data.read_value <= rd_q;
      out_data.batch_end  <= item.last_of_batch;
    end
  end

  always_comb begin
    state_next    = state;
    status_q_next = status_q;
    rd_q_next     = rd_q;
    out_load      = 1'b0;
    scmd.op       = cme_pkg::SOP_NONE;
    scmd.row      = item.row;
    scmd.col      = item.col;
    scmd.slot     = item.slot;
    vop           = cme_pkg::VOP_NONE;
    unique case (state)
      cme_pkg::ST_BOOT: begin
        // Wait for the value memory to finish its power-up clearing sweep.
        if (vdone) begin
          state_next = cme_pkg::ST_IDLE;
        end
      end
      cme_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cme_pkg::ST_DISPATCH;
        end
      end
      cme_pkg::ST_DISPATCH: begin
        rd_q_next     = '0;
        status_q_next = cme_pkg::STS_OK;
        state_next    = cme_pkg::ST_DONE;
        unique case (item.func)
          cme_pkg::FN_LOAD_ROW: begin
            if (32'(item.row) <= 32'(MAX_ROWS)) begin
              scmd.op = cme_pkg::SOP_LOAD_ROW;
            end else begin
              status_q_next = cme_pkg::STS_ROW_RANGE;
            end
          end
          cme_pkg::FN_LOAD_COL: begin
            if ((32'(item.slot) < 32'(MAX_ENTRIES)) && (32'(item.col) < 32'(MAX_COLS))) begin
              scmd.op = cme_pkg::SOP_LOAD_COL;
            end else begin
              status_q_next = cme_pkg::STS_NOT_FOUND;
            end
          end
          cme_pkg::FN_SET, cme_pkg::FN_ADD, cme_pkg::FN_ERASE, cme_pkg::FN_READ: begin
            if (row_bad) begin
              status_q_next = cme_pkg::STS_ROW_RANGE;
            end else begin
              scmd.op    = cme_pkg::SOP_FIND;
              state_next = cme_pkg::ST_SEARCH;
            end
          end
          cme_pkg::FN_CLEAR: begin
            vop        = cme_pkg::VOP_CLEAR;
            state_next = cme_pkg::ST_VALUE;
          end
          cme_pkg::FN_NOP: ;
        endcase
      end
      cme_pkg::ST_SEARCH: begin
        if (sres.done) begin
          if (!sres.found) begin
            // Set and add need the element; erase and read quietly skip it.
            if (item.func == cme_pkg::FN_SET || item.func == cme_pkg::FN_ADD) begin
              status_q_next = cme_pkg::STS_NOT_FOUND;
            end
            state_next = cme_pkg::ST_DONE;
          end else begin
            unique case (item.func)
              cme_pkg::FN_SET:   vop = cme_pkg::VOP_SET;
              cme_pkg::FN_ADD:   vop = cme_pkg::VOP_ADD;
              cme_pkg::FN_ERASE: vop = cme_pkg::VOP_ERASE;
              cme_pkg::FN_READ:  vop = cme_pkg::VOP_READ;
              default:           vop = cme_pkg::VOP_NONE;
            endcase
            state_next = cme_pkg::ST_VALUE;
          end
        end
      end
      cme_pkg::ST_VALUE: begin
        if (vdone) begin
          if (item.func == cme_pkg::FN_READ) begin
            rd_q_next = vrdata;
          end
          state_next = cme_pkg::ST_DONE;
        end
      end
      cme_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = cme_pkg::ST_IDLE;
        end
      end
      default: state_next = cme_pkg::ST_IDLE;
    endcase
  end

  cme_scale u_scale (
    .clk        (clk),
    .value      (item.value),
    .multiplier (multiplier),
    .scaled     (scaled)
  );

  cme_search #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_search (
    .clk  (clk),
    .rst  (rst),
    .cmd  (scmd),
    .res  (sres),
    .slot (sslot)
  );

  cme_value #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_value (
    .clk    (clk),
    .rst    (rst),
    .op     (vop),
    .slot   (sslot),
    .scaled (scaled),
    .done   (vdone),
    .rdata  (vrdata)
  );

`ifndef SYNTHESIS
  // A search can only finish while the controller waits for it.
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    sres.done |-> (state == cme_pkg::ST_SEARCH))
    else $error("search finished outside of a search");

  // Value memory completions belong to a value operation or the power-up sweep.
  a_value_done: assert property (@(posedge clk) disable iff (rst)
    vdone |-> (state == cme_pkg::ST_VALUE || state == cme_pkg::ST_BOOT))
    else $error("value memory finished with no operation pending");

  // A finished result moves to the output register as soon as it is free.
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (state == cme_pkg::ST_DONE && !(out_valid && out_stall)) |=>
      (state == cme_pkg::ST_IDLE && out_valid))
    else $error("result held back while the output register was free");
`endif

endmodule
